// File: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication, disabled in reset
`define BKVT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked implication checked only while a transfer is offered
`define BKVT_ASSERT_VALID(label, clk, rst_n, vld, prop, msg) \
  `BKVT_ASSERT(label, clk, rst_n, (vld) |-> (prop), msg)

`endif

// File: hw/rtl/bkvt_pkg.sv
// ----------------------------------------------------------------------------
// bkvt_pkg
// types, character codes and event codes of the block key/value tokenizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bkvt_pkg;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;

  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_NAME_CHAR = 4'd1;
  localparam logic [3:0] EV_NAME_DONE = 4'd2;
  localparam logic [3:0] EV_KEY_CHAR  = 4'd3;
  localparam logic [3:0] EV_KEY_DONE  = 4'd4;
  localparam logic [3:0] EV_VAL_CHAR  = 4'd5;
  localparam logic [3:0] EV_VAL_DONE  = 4'd6;
  localparam logic [3:0] EV_CLOSED    = 4'd7;
  localparam logic [3:0] EV_ERROR     = 4'd8;
  localparam logic [3:0] EV_END_OK    = 4'd9;
  localparam logic [3:0] EV_END_BAD   = 4'd10;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNEXPECT  = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG  = 2'd2;
  localparam logic [1:0] ERR_TOO_MANY  = 2'd3;

  localparam logic [2:0] GLOBAL_LEN    = 3'd6;
  localparam logic [2:0] GLOBAL_NOMATCH = 3'd7;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] chr;
    logic       end_mark;
    logic       is_ws;
    logic       is_lf;
    logic       is_lbrace;
    logic       is_rbrace;
    logic       is_colon;
    logic       is_semi;
  } item_t;

  function automatic logic [7:0] global_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h67;
      3'd1:    ch = 8'h6c;
      3'd2:    ch = 8'h6f;
      3'd3:    ch = 8'h62;
      3'd4:    ch = 8'h61;
      3'd5:    ch = 8'h6c;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bkvt_in_if.sv
// ----------------------------------------------------------------------------
// bkvt_in_if
// input byte channel: valid/ready with text byte and end marker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bkvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_marker;

  modport source (output valid, output text_byte, output end_marker, input ready);
  modport sink   (input valid, input text_byte, input end_marker, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bkvt_out_if.sv
// ----------------------------------------------------------------------------
// bkvt_out_if
// result channel: valid/ready with one token event per transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bkvt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [7:0]  char_out;
  logic        scope_is_global;
  logic [6:0]  block_number;
  logic        block_closed;
  logic [1:0]  error_code;
  logic [15:0] line_number;

  modport source (output valid, output event_res, output char_out,
                  output scope_is_global, output block_number, output block_closed,
                  output error_code, output line_number, input ready);
  modport sink   (input valid, input event_res, input char_out,
                  input scope_is_global, input block_number, input block_closed,
                  input error_code, input line_number, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/block_key_value_tokenizer_top.sv
// ----------------------------------------------------------------------------
// block_key_value_tokenizer_top
// byte-stream tokenizer for blocks of the form  name { key: value; }
//
// in_ch carries one text byte or an end marker per transfer; out_ch carries
// exactly one event per input transfer, in order. the front blanks comments
// and classifies the byte into a two-entry queue; the back runs the parse
// phase machine and holds the result in an output register.
// throughput: one byte per cycle while out_ch is not stalled. a byte
// accepted on in_ch is written into the queue, then taken by the back into
// the output register, from which its result is shown on out_ch.
// while out_ch is stalled the back holds its result, the queue takes up to
// two more bytes and then in_ch.ready drops; no byte is lost.
// reset (rst_n low, synchronous) empties the queue, drops out_ch.valid and
// returns phase, counters, comment and error state to the start of a text.
// an end marker reports the final check and clears the same state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module block_key_value_tokenizer_top #(
  parameter int MAX_BLOCKS = 128,
  parameter int WORD_LIMIT = 128
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bkvt_in_if.sink    in_ch,
  bkvt_out_if.source out_ch
);

  bkvt_pkg::item_t push_item;
  bkvt_pkg::item_t pop_item;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_not_empty;
  logic            err_pair_ok;
  logic            char_pair_ok;
  logic            closed_pair_ok;

  bkvt_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_item (push_item),
    .q_push (push)
  );

  bkvt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (q_not_empty)
  );

  bkvt_back #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_LIMIT (WORD_LIMIT)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (pop_item),
    .q_valid (q_not_empty),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

  // result field consistency
  assign err_pair_ok    = ((out_ch.error_code != bkvt_pkg::ERR_NONE) ==
                           (out_ch.event_res == bkvt_pkg::EV_ERROR));
  assign char_pair_ok   = (out_ch.char_out == 8'd0) ||
                          (out_ch.event_res inside {bkvt_pkg::EV_NAME_CHAR,
                                                    bkvt_pkg::EV_KEY_CHAR,
                                                    bkvt_pkg::EV_VAL_CHAR});
  assign closed_pair_ok = !out_ch.block_closed ||
                          (out_ch.event_res inside {bkvt_pkg::EV_CLOSED,
                                                    bkvt_pkg::EV_VAL_DONE});

  `BKVT_ASSERT_VALID(a_err_code, clk, rst_n, out_ch.valid, err_pair_ok, "error code off event")
  `BKVT_ASSERT_VALID(a_char_ev, clk, rst_n, out_ch.valid, char_pair_ok, "stray character")
  `BKVT_ASSERT_VALID(a_closed_ev, clk, rst_n, out_ch.valid, closed_pair_ok, "stray block close")
  `BKVT_ASSERT(a_pop_has_data, clk, rst_n, pop |-> q_not_empty, "queue popped while empty")

endmodule

`default_nettype wire

// File: hw/rtl/bkvt_front.sv
// ----------------------------------------------------------------------------
// bkvt_front
// accepts bytes, blanks comments and classifies each byte for the parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bkvt_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  bkvt_in_if.sink            in_ch,
  input  wire logic          q_full,
  output bkvt_pkg::item_t    q_item,
  output logic               q_push
);

  logic       in_comment_r;
  logic       in_comment_nxt;
  logic [7:0] chr;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    chr            = in_ch.text_byte;
    in_comment_nxt = in_comment_r;
    if (in_ch.end_marker) begin
      in_comment_nxt = 1'b0;
    end else if (!in_comment_r) begin
      if (in_ch.text_byte == bkvt_pkg::CH_HASH) begin
        chr            = bkvt_pkg::CH_SPACE;
        in_comment_nxt = 1'b1;
      end
    end else if (in_ch.text_byte == bkvt_pkg::CH_LF) begin
      in_comment_nxt = 1'b0;
    end else begin
      chr = bkvt_pkg::CH_SPACE;
    end
  end

  always_comb begin
    q_item.chr       = chr;
    q_item.end_mark  = in_ch.end_marker;
    q_item.is_lf     = (chr == bkvt_pkg::CH_LF);
    q_item.is_ws     = (chr == bkvt_pkg::CH_SPACE) || (chr == bkvt_pkg::CH_TAB) ||
                       (chr == bkvt_pkg::CH_CR) || (chr == bkvt_pkg::CH_LF);
    q_item.is_lbrace = (chr == bkvt_pkg::CH_LBRACE);
    q_item.is_rbrace = (chr == bkvt_pkg::CH_RBRACE);
    q_item.is_colon  = (chr == bkvt_pkg::CH_COLON);
    q_item.is_semi   = (chr == bkvt_pkg::CH_SEMI);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_comment_r <= 1'b0;
    end else if (q_push) begin
      in_comment_r <= in_comment_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bkvt_fifo.sv
// ----------------------------------------------------------------------------
// bkvt_fifo
// two-entry queue of classified bytes between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bkvt_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire bkvt_pkg::item_t  push_item,
  output logic                  full,
  input  wire logic             pop,
  output bkvt_pkg::item_t       pop_item,
  output logic                  not_empty
);

  bkvt_pkg::item_t slot_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;
  logic [1:0]      count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_item  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bkvt_back.sv
// ----------------------------------------------------------------------------
// bkvt_back
// parse phase machine, block and line counters and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bkvt_back #(
  parameter int MAX_BLOCKS = 128,
  parameter int WORD_LIMIT = 128
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bkvt_pkg::item_t  q_item,
  input  wire logic             q_valid,
  output logic                  q_pop,
  bkvt_out_if.source            out_ch
);

  localparam int WL_W = $clog2(WORD_LIMIT);
  localparam int BS_W = $clog2(MAX_BLOCKS + 1);

  localparam logic [2:0] PH_NAME  = 3'd0;
  localparam logic [2:0] PH_OPEN  = 3'd1;
  localparam logic [2:0] PH_KEY   = 3'd2;
  localparam logic [2:0] PH_COLON = 3'd3;
  localparam logic [2:0] PH_VALUE = 3'd4;
  localparam logic [2:0] PH_SEMI  = 3'd5;

  logic [2:0]      phase_r, phase_nxt;
  logic [WL_W-1:0] wl_r, wl_nxt;
  logic [2:0]      gmp_r, gmp_nxt;
  logic            cig_r, cig_nxt;
  logic [BS_W-1:0] bs_r, bs_nxt;
  logic [15:0]     lines_r, lines_nxt;
  logic            err_r, err_nxt;

  logic            out_valid_r;
  logic [3:0]      ev_r;
  logic [7:0]      chr_r;
  logic            glob_r;
  logic [6:0]      bn_r;
  logic            closed_r;
  logic [1:0]      code_r;
  logic [15:0]     line_r;

  logic [3:0]      ev;
  logic [7:0]      chr_o;
  logic            closed;
  logic [1:0]      code;
  logic            glob_o;
  logic [6:0]      bn_o;
  logic            full;
  logic            take;
  logic            name_g;
  logic            c_ws;
  logic            c_lb;
  logic            c_rb;
  logic            c_col;
  logic            c_semi;
  logic            wl_zero;

  function automatic logic [6:0] block_idx(input logic glob, input logic [BS_W-1:0] bs);
    logic [8:0] bs9;
    bs9 = 9'(bs);
    if (glob || bs9 == 9'd0) begin
      return 7'd0;
    end
    return 7'(bs9 - 9'd1);
  endfunction

  assign take  = q_valid && (!out_valid_r || out_ch.ready);
  assign q_pop = take;

  assign c_ws    = q_item.is_ws;
  assign c_lb    = q_item.is_lbrace;
  assign c_rb    = q_item.is_rbrace;
  assign c_col   = q_item.is_colon;
  assign c_semi  = q_item.is_semi;
  assign wl_zero = (wl_r == '0);
  assign full    = (9'(wl_r) >= 9'(WORD_LIMIT - 1));
  assign name_g  = (gmp_r == bkvt_pkg::GLOBAL_LEN);

  always_comb begin
    phase_nxt = phase_r;
    wl_nxt    = wl_r;
    gmp_nxt   = gmp_r;
    cig_nxt   = cig_r;
    bs_nxt    = bs_r;
    lines_nxt = lines_r;
    err_nxt   = err_r;
    ev        = bkvt_pkg::EV_NONE;
    chr_o     = 8'd0;
    closed    = 1'b0;
    code      = bkvt_pkg::ERR_NONE;
    glob_o    = cig_r;
    bn_o      = block_idx(cig_r, bs_r);

    if (q_item.end_mark) begin
      ev        = (!err_r && phase_r == PH_NAME && wl_zero) ? bkvt_pkg::EV_END_OK
                                                            : bkvt_pkg::EV_END_BAD;
      phase_nxt = PH_NAME;
      wl_nxt    = '0;
      gmp_nxt   = 3'd0;
      cig_nxt   = 1'b0;
      bs_nxt    = '0;
      lines_nxt = 16'd0;
      err_nxt   = 1'b0;
    end else if (!err_r) begin
      case (phase_r)
        PH_NAME: begin
          if (wl_zero && c_ws) begin
          end else if (wl_zero && c_lb) begin
            code = bkvt_pkg::ERR_UNEXPECT;
          end else if (full) begin
            code = bkvt_pkg::ERR_TOO_LONG;
          end else if (c_rb || c_col) begin
            code = bkvt_pkg::ERR_UNEXPECT;
          end else if (c_ws || c_lb) begin
            cig_nxt = name_g;
            gmp_nxt = 3'd0;
            if (!name_g && 9'(bs_r) >= 9'(MAX_BLOCKS)) begin
              code = bkvt_pkg::ERR_TOO_MANY;
            end else begin
              if (!name_g) begin
                bs_nxt = bs_r + BS_W'(1);
              end
              ev        = bkvt_pkg::EV_NAME_DONE;
              phase_nxt = c_lb ? PH_KEY : PH_OPEN;
              wl_nxt    = '0;
            end
          end else begin
            if (gmp_r < bkvt_pkg::GLOBAL_LEN && q_item.chr == bkvt_pkg::global_char(gmp_r)) begin
              gmp_nxt = gmp_r + 3'd1;
            end else begin
              gmp_nxt = bkvt_pkg::GLOBAL_NOMATCH;
            end
            wl_nxt = wl_r + WL_W'(1);
            ev     = bkvt_pkg::EV_NAME_CHAR;
            chr_o  = q_item.chr;
          end
        end
        PH_OPEN: begin
          if (c_ws) begin
          end else if (c_lb) begin
            phase_nxt = PH_KEY;
            wl_nxt    = '0;
          end else begin
            code = bkvt_pkg::ERR_UNEXPECT;
          end
        end
        PH_KEY: begin
          if (wl_zero && c_ws) begin
          end else if (wl_zero && c_col) begin
            code = bkvt_pkg::ERR_UNEXPECT;
          end else if (wl_zero && c_rb) begin
            phase_nxt = PH_NAME;
            ev        = bkvt_pkg::EV_CLOSED;
            closed    = 1'b1;
          end else if (full) begin
            code = bkvt_pkg::ERR_TOO_LONG;
          end else if (c_lb || c_rb) begin
            code = bkvt_pkg::ERR_UNEXPECT;
          end else if (c_ws || c_col) begin
            ev        = bkvt_pkg::EV_KEY_DONE;
            phase_nxt = c_col ? PH_VALUE : PH_COLON;
            wl_nxt    = '0;
          end else begin
            wl_nxt = wl_r + WL_W'(1);
            ev     = bkvt_pkg::EV_KEY_CHAR;
            chr_o  = q_item.chr;
          end
        end
        PH_COLON: begin
          if (c_ws) begin
          end else if (c_col) begin
            phase_nxt = PH_VALUE;
            wl_nxt    = '0;
          end else begin
            code = bkvt_pkg::ERR_UNEXPECT;
          end
        end
        PH_VALUE: begin
          if (wl_zero && c_ws) begin
          end else if (full) begin
            code = bkvt_pkg::ERR_TOO_LONG;
          end else if (c_col || c_lb) begin
            code = bkvt_pkg::ERR_UNEXPECT;
          end else if (c_ws || c_semi || c_rb) begin
            ev = bkvt_pkg::EV_VAL_DONE;
            if (c_semi) begin
              phase_nxt = PH_KEY;
            end else if (c_rb) begin
              phase_nxt = PH_NAME;
              closed    = 1'b1;
            end else begin
              phase_nxt = PH_SEMI;
            end
            wl_nxt = '0;
          end else begin
            wl_nxt = wl_r + WL_W'(1);
            ev     = bkvt_pkg::EV_VAL_CHAR;
            chr_o  = q_item.chr;
          end
        end
        default: begin
          if (c_ws) begin
          end else if (c_semi) begin
            phase_nxt = PH_KEY;
            wl_nxt    = '0;
          end else if (c_rb) begin
            phase_nxt = PH_NAME;
            wl_nxt    = '0;
            ev        = bkvt_pkg::EV_CLOSED;
            closed    = 1'b1;
          end else begin
            code = bkvt_pkg::ERR_UNEXPECT;
          end
        end
      endcase

      if (code != bkvt_pkg::ERR_NONE) begin
        if (code == bkvt_pkg::ERR_TOO_MANY) begin
          cig_nxt = 1'b0;
        end
        err_nxt = 1'b1;
        ev      = bkvt_pkg::EV_ERROR;
        chr_o   = 8'd0;
        closed  = 1'b0;
      end else if (q_item.is_lf && lines_r != 16'hffff) begin
        lines_nxt = lines_r + 16'd1;
      end
      glob_o = cig_nxt;
      bn_o   = block_idx(cig_nxt, bs_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_NAME;
      wl_r        <= '0;
      gmp_r       <= 3'd0;
      cig_r       <= 1'b0;
      bs_r        <= '0;
      lines_r     <= 16'd0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r     <= phase_nxt;
        wl_r        <= wl_nxt;
        gmp_r       <= gmp_nxt;
        cig_r       <= cig_nxt;
        bs_r        <= bs_nxt;
        lines_r     <= lines_nxt;
        err_r       <= err_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ev_r     <= ev;
      chr_r    <= chr_o;
      glob_r   <= glob_o;
      bn_r     <= bn_o;
      closed_r <= closed;
      code_r   <= code;
      line_r   <= lines_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.event_res       = ev_r;
  assign out_ch.char_out        = chr_r;
  assign out_ch.scope_is_global = glob_r;
  assign out_ch.block_number    = bn_r;
  assign out_ch.block_closed    = closed_r;
  assign out_ch.error_code      = code_r;
  assign out_ch.line_number     = line_r;

endmodule

`default_nettype wire
